// ----- hw/rtl/vctp_pkg.sv -----
package vctp_pkg;

  localparam int IN_W    = 12;
  localparam int TRIG_W  = 18;
  localparam int SC_W    = 36;
  localparam int OFF_W   = 14;
  localparam int CTR_W   = 11;
  localparam int SCR_W   = 19;
  localparam int DEPTH_W = 17;
  localparam int VIEW_W  = 16;
  localparam int MAG_W   = 22;
  localparam int DIV_W   = 21;
  localparam int IDX_W   = 3;

  localparam int NEAR_LIMIT = 50;
  localparam logic signed [SCR_W-1:0] CLIP_SCREEN_X = -19'sd5000;

  localparam logic [IDX_W-1:0] REG_MODEL_YAW    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CAMERA_PITCH = 3'd1;
  localparam logic [IDX_W-1:0] REG_CAMERA_YAW   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_X     = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET_Y     = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET_Z     = 3'd5;
  localparam logic [IDX_W-1:0] REG_MID_X        = 3'd6;
  localparam logic [IDX_W-1:0] REG_MID_Y        = 3'd7;

  typedef struct packed {
    logic [SC_W-1:0]  model_sc;
    logic [SC_W-1:0]  pitch_sc;
    logic [SC_W-1:0]  yaw_sc;
    logic [OFF_W-1:0] off_x;
    logic [OFF_W-1:0] off_y;
    logic [OFF_W-1:0] off_z;
    logic [CTR_W-1:0] mid_x;
    logic [CTR_W-1:0] mid_y;
  } cfg_t;

  typedef struct packed {
    logic               near;
    logic [DEPTH_W-1:0] depth;
    logic [VIEW_W-1:0]  view_x;
    logic [VIEW_W-1:0]  view_y;
    logic [VIEW_W-1:0]  view_z;
    logic               last;
    logic               neg_x;
    logic               neg_y;
  } side_t;

endpackage

// ----- hw/rtl/vctp_transform.sv -----
module vctp_transform (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  vctp_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  input  logic signed [vctp_pkg::IN_W-1:0] in_x,
  input  logic signed [vctp_pkg::IN_W-1:0] in_y,
  input  logic signed [vctp_pkg::IN_W-1:0] in_z,
  input  logic                           in_last,
  output logic                           out_valid,
  output vctp_pkg::side_t                out_side,
  output logic [vctp_pkg::MAG_W-1:0]     out_mag_x,
  output logic [vctp_pkg::MAG_W-1:0]     out_mag_y,
  output logic [vctp_pkg::DIV_W-1:0]     out_den
);

  logic signed [17:0] ms, mc, ps, pc, ys, yc;
  logic signed [13:0] sox, soy, soz;

  assign ms  = $signed(cfg.model_sc[35:18]);
  assign mc  = $signed(cfg.model_sc[17:0]);
  assign ps  = $signed(cfg.pitch_sc[35:18]);
  assign pc  = $signed(cfg.pitch_sc[17:0]);
  assign ys  = $signed(cfg.yaw_sc[35:18]);
  assign yc  = $signed(cfg.yaw_sc[17:0]);
  assign sox = $signed(cfg.off_x);
  assign soy = $signed(cfg.off_y);
  assign soz = $signed(cfg.off_z);

  logic v1, v2, v3, v4, v5, v6;
  logic l1, l2, l3, l4, l5, l6;

  // stage 1: model yaw products, reference depth products
  logic signed [29:0] p1_zs, p1_xc, p1_zc, p1_xs;
  logic signed [31:0] r1_zc, r1_xs;
  logic signed [11:0] y1;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_zs <= 30'(in_z) * 30'(ms);
      p1_xc <= 30'(in_x) * 30'(mc);
      p1_zc <= 30'(in_z) * 30'(mc);
      p1_xs <= 30'(in_x) * 30'(ms);
      r1_zc <= 32'(soz) * 32'(yc);
      r1_xs <= 32'(sox) * 32'(ys);
      y1    <= in_y;
      l1    <= in_last;
    end
  end

  // stage 2: floor shift and scene offset
  logic signed [30:0] s2_a, s2_b;
  logic signed [32:0] r2_s;
  logic signed [15:0] x2, z2;
  logic signed [14:0] y2;
  logic signed [16:0] rt2;

  assign s2_a = 31'(p1_zs) + 31'(p1_xc);
  assign s2_b = 31'(p1_zc) - 31'(p1_xs);
  assign r2_s = 33'(r1_zc) - 33'(r1_xs);

  always_ff @(posedge clk) begin
    if (en) begin
      x2  <= 16'($signed(s2_a[30:16])) + 16'(sox);
      z2  <= 16'($signed(s2_b[30:16])) + 16'(soz);
      y2  <= 15'(y1) + 15'(soy);
      rt2 <= $signed(r2_s[32:16]);
      l2  <= l1;
    end
  end

  // stage 3: camera yaw products
  logic signed [33:0] p3_zs, p3_xc, p3_zc, p3_xs;
  logic signed [31:0] r3_ys;
  logic signed [34:0] r3_tc;
  logic signed [14:0] y3;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_zs <= 34'(z2) * 34'(ys);
      p3_xc <= 34'(x2) * 34'(yc);
      p3_zc <= 34'(z2) * 34'(yc);
      p3_xs <= 34'(x2) * 34'(ys);
      r3_ys <= 32'(soy) * 32'(ps);
      r3_tc <= 35'(rt2) * 35'(pc);
      y3    <= y2;
      l3    <= l2;
    end
  end

  // stage 4
  logic signed [34:0] s4_a, s4_b;
  logic signed [35:0] r4_s;
  logic signed [18:0] x4, z4;
  logic signed [14:0] y4;
  logic signed [19:0] ref4;

  assign s4_a = 35'(p3_zs) + 35'(p3_xc);
  assign s4_b = 35'(p3_zc) - 35'(p3_xs);
  assign r4_s = 36'(r3_ys) + 36'(r3_tc);

  always_ff @(posedge clk) begin
    if (en) begin
      x4   <= $signed(s4_a[34:16]);
      z4   <= $signed(s4_b[34:16]);
      y4   <= y3;
      ref4 <= $signed(r4_s[35:16]);
      l4   <= l3;
    end
  end

  // stage 5: camera pitch products
  logic signed [32:0] p5_yc, p5_ys;
  logic signed [36:0] p5_zs, p5_zc;
  logic signed [18:0] x5;
  logic signed [19:0] ref5;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_yc <= 33'(y4) * 33'(pc);
      p5_zs <= 37'(z4) * 37'(ps);
      p5_ys <= 33'(y4) * 33'(ps);
      p5_zc <= 37'(z4) * 37'(pc);
      x5    <= x4;
      ref5  <= ref4;
      l5    <= l4;
    end
  end

  // stage 6
  logic signed [37:0] s6_y, s6_z;
  logic signed [18:0] x6;
  logic signed [21:0] y6, z6;
  logic signed [19:0] ref6;

  assign s6_y = 38'(p5_yc) - 38'(p5_zs);
  assign s6_z = 38'(p5_ys) + 38'(p5_zc);

  always_ff @(posedge clk) begin
    if (en) begin
      x6   <= x5;
      y6   <= $signed(s6_y[37:16]);
      z6   <= $signed(s6_z[37:16]);
      ref6 <= ref5;
      l6   <= l5;
    end
  end

  // stage 7: near test, depth, magnitudes for the divider
  logic signed [21:0] xe;
  logic signed [22:0] dd;

  assign xe = 22'(x6);
  assign dd = 23'(z6) - 23'(ref6);

  always_ff @(posedge clk) begin
    if (en) begin
      out_side.near   <= z6 < 22'(vctp_pkg::NEAR_LIMIT);
      out_side.depth  <= dd[vctp_pkg::DEPTH_W-1:0];
      out_side.view_x <= x6[vctp_pkg::VIEW_W-1:0];
      out_side.view_y <= y6[vctp_pkg::VIEW_W-1:0];
      out_side.view_z <= z6[vctp_pkg::VIEW_W-1:0];
      out_side.last   <= l6;
      out_side.neg_x  <= xe[21];
      out_side.neg_y  <= y6[21];
      out_mag_x       <= xe[21] ? -xe : xe;
      out_mag_y       <= y6[21] ? -y6 : y6;
      out_den         <= z6[vctp_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

endmodule

// ----- hw/rtl/vctp_divider.sv -----
module vctp_divider #(
  parameter int NW = 31,
  parameter int DW = 21
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  // restoring division, one quotient bit per stage, MSB first
  logic [NW-1:0] n_r [NW];
  logic [DW-1:0] r_r [NW];
  logic [DW-1:0] d_r [NW];
  logic [NW-1:0] q_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] n_in, q_in;
    logic [DW-1:0] r_in, d_in;
    logic [DW:0]   trial, diff;

    if (k == 0) begin : g_first
      assign n_in = num;
      assign r_in = '0;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign n_in = n_r[k-1];
      assign r_in = r_r[k-1];
      assign d_in = d_r[k-1];
      assign q_in = q_r[k-1];
    end

    assign trial = {r_in, n_in[NW-1]};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= {n_in[NW-2:0], 1'b0};
        r_r[k] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
        d_r[k] <= d_in;
        q_r[k] <= {q_in[NW-2:0], ~diff[DW]};
      end
    end
  end

  assign quo = q_r[NW-1];

endmodule

// ----- hw/rtl/vertex_camera_transform_project_top.sv -----
// Vertex transform and perspective projection, one vertex per item.
// Slave stream: tdata carries vertex x, y, z (12-bit signed each), tlast
// marks the final vertex of a model. Master stream: tdata carries screen x,
// screen y, relative depth and view x, y, z; tuser is the near-clip flag;
// tlast follows the input tlast.
// Config registers are written through wr_en / wr_index / wr_data; the user
// must write them only while no item is in flight, as the block does not
// enforce it; they take effect for the next item accepted. Throughput: one
// item per cycle while the output is not stalled; each item passes seven
// stages of rotation multipliers and sums, one stage per quotient bit of
// the 22 + FOCAL_SHIFT bit restoring divider, and the output register.
// Reset clears all valid bits and loads the register reset values.
// When the receiver holds tready low with a result waiting, the whole
// pipeline freezes and s_tready falls in the same cycle; nothing is
// dropped or repeated.
module vertex_camera_transform_project_top #(
  parameter int FOCAL_SHIFT = 9
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // vertex_x, vertex_y, vertex_z, 4'b0
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // screen_x, screen_y, relative_depth, view_x, view_y, view_z, 1'b0
  output logic [103:0] m_tdata,
  output logic         m_tuser,   // near_clipped
  output logic         m_tlast,
  input  logic         wr_en,
  input  logic [vctp_pkg::IDX_W-1:0] wr_index,
  input  logic [vctp_pkg::SC_W-1:0]  wr_data
);

  localparam int NW = vctp_pkg::MAG_W + FOCAL_SHIFT;

  vctp_pkg::cfg_t cfg;
  logic           en;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.model_sc <= 36'd65536;
      cfg.pitch_sc <= 36'd65536;
      cfg.yaw_sc   <= 36'd65536;
      cfg.off_x    <= '0;
      cfg.off_y    <= '0;
      cfg.off_z    <= '0;
      cfg.mid_x    <= 11'd256;
      cfg.mid_y    <= 11'd167;
    end else if (wr_en) begin
      case (wr_index)
        vctp_pkg::REG_MODEL_YAW:    cfg.model_sc <= wr_data;
        vctp_pkg::REG_CAMERA_PITCH: cfg.pitch_sc <= wr_data;
        vctp_pkg::REG_CAMERA_YAW:   cfg.yaw_sc   <= wr_data;
        vctp_pkg::REG_OFFSET_X:     cfg.off_x    <= wr_data[vctp_pkg::OFF_W-1:0];
        vctp_pkg::REG_OFFSET_Y:     cfg.off_y    <= wr_data[vctp_pkg::OFF_W-1:0];
        vctp_pkg::REG_OFFSET_Z:     cfg.off_z    <= wr_data[vctp_pkg::OFF_W-1:0];
        vctp_pkg::REG_MID_X:        cfg.mid_x    <= wr_data[vctp_pkg::CTR_W-1:0];
        vctp_pkg::REG_MID_Y:        cfg.mid_y    <= wr_data[vctp_pkg::CTR_W-1:0];
        default: ;
      endcase
    end
  end

  logic                          t_valid;
  vctp_pkg::side_t               t_side;
  logic [vctp_pkg::MAG_W-1:0]    t_mag_x, t_mag_y;
  logic [vctp_pkg::DIV_W-1:0]    t_den;

  vctp_transform u_transform (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_x      ($signed(s_tdata[11:0])),
    .in_y      ($signed(s_tdata[23:12])),
    .in_z      ($signed(s_tdata[35:24])),
    .in_last   (s_tlast),
    .out_valid (t_valid),
    .out_side  (t_side),
    .out_mag_x (t_mag_x),
    .out_mag_y (t_mag_y),
    .out_den   (t_den)
  );

  logic [NW-1:0] quo_x, quo_y;

  vctp_divider #(.NW(NW), .DW(vctp_pkg::DIV_W)) u_div_x (
    .clk (clk),
    .en  (en),
    .num ({t_mag_x, {FOCAL_SHIFT{1'b0}}}),
    .den (t_den),
    .quo (quo_x)
  );

  vctp_divider #(.NW(NW), .DW(vctp_pkg::DIV_W)) u_div_y (
    .clk (clk),
    .en  (en),
    .num ({t_mag_y, {FOCAL_SHIFT{1'b0}}}),
    .den (t_den),
    .quo (quo_y)
  );

  // side data and valid bits ride alongside the divider stages
  vctp_pkg::side_t sd [NW];
  logic            dv [NW];

  for (genvar k = 0; k < NW; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) sd[k] <= (k == 0) ? t_side : sd[(k == 0) ? 0 : k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) dv[k] <= 1'b0;
      else if (en) dv[k] <= (k == 0) ? t_valid : dv[(k == 0) ? 0 : k-1];
    end
  end

  vctp_pkg::side_t                fin;
  logic [vctp_pkg::SCR_W-1:0]     qx, qy, px, py, scr_x, scr_y;
  logic [vctp_pkg::SCR_W-1:0]     cx, cy;

  assign fin = sd[NW-1];
  assign qx  = quo_x[vctp_pkg::SCR_W-1:0];
  assign qy  = quo_y[vctp_pkg::SCR_W-1:0];
  assign px  = fin.neg_x ? -qx : qx;
  assign py  = fin.neg_y ? -qy : qy;
  assign cx  = {{(vctp_pkg::SCR_W-vctp_pkg::CTR_W){1'b0}}, cfg.mid_x};
  assign cy  = {{(vctp_pkg::SCR_W-vctp_pkg::CTR_W){1'b0}}, cfg.mid_y};
  assign scr_x = fin.near ? vctp_pkg::CLIP_SCREEN_X : (cx + px);
  assign scr_y = fin.near ? '0 : (cy + py);

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= dv[NW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, fin.view_z, fin.view_y, fin.view_x, fin.depth, scr_y, scr_x};
      m_tuser <= fin.near;
      m_tlast <= fin.last;
    end
  end

endmodule

// ----- bench/vctp_checker.sv -----
module vctp_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [39:0]  s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  input  logic         m_tuser,
  input  logic         m_tlast,
  input  logic         wr_en,
  input  logic [vctp_pkg::IDX_W-1:0] wr_index,
  input  logic [vctp_pkg::SC_W-1:0]  wr_data,
  output int           fail_count,
  output int           pending,
  output int           seen_results,
  output int           seen_clipped
);

  localparam int FOCAL = 9;

  typedef struct packed {
    logic [vctp_pkg::SCR_W-1:0]   scr_x;
    logic [vctp_pkg::SCR_W-1:0]   scr_y;
    logic [vctp_pkg::DEPTH_W-1:0] depth;
    logic                         near;
    logic [vctp_pkg::VIEW_W-1:0]  vx;
    logic [vctp_pkg::VIEW_W-1:0]  vy;
    logic [vctp_pkg::VIEW_W-1:0]  vz;
    logic                         last;
  } proj_t;

  proj_t projections[$];

  logic [vctp_pkg::SC_W-1:0]  model_sc, pitch_sc, yaw_sc;
  logic [vctp_pkg::OFF_W-1:0] ofs_x, ofs_y, ofs_z;
  logic [vctp_pkg::CTR_W-1:0] ctr_x, ctr_y;

  // floor division by 2^16 on signed 64-bit
  function automatic longint q16(longint v);
    return v >>> 16;
  endfunction

  function automatic proj_t project(logic [39:0] d, logic lst);
    longint x, y, z, sx, sy, sz, ms, mc, ps, pc, ys, yc, t, rd, ox, oy;
    proj_t r;
    x  = longint'($signed(d[11:0]));
    y  = longint'($signed(d[23:12]));
    z  = longint'($signed(d[35:24]));
    sx = longint'($signed(ofs_x));
    sy = longint'($signed(ofs_y));
    sz = longint'($signed(ofs_z));
    ms = longint'($signed(model_sc[35:18])); mc = longint'($signed(model_sc[17:0]));
    ps = longint'($signed(pitch_sc[35:18])); pc = longint'($signed(pitch_sc[17:0]));
    ys = longint'($signed(yaw_sc[35:18]));   yc = longint'($signed(yaw_sc[17:0]));
    t  = q16(sz * yc - sx * ys);
    rd = q16(sy * ps + t * pc);
    t  = q16(z * ms + x * mc);
    z  = q16(z * mc - x * ms);
    x  = t + sx; y = y + sy; z = z + sz;
    t  = q16(z * ys + x * yc);
    z  = q16(z * yc - x * ys);
    x  = t;
    t  = q16(y * pc - z * ps);
    z  = q16(y * ps + z * pc);
    y  = t;
    r.near = (z < vctp_pkg::NEAR_LIMIT);
    if (r.near) begin
      ox = -5000;
      oy = 0;
    end else begin
      ox = longint'(ctr_x) + (x * (64'sd1 <<< FOCAL)) / z;
      oy = longint'(ctr_y) + (y * (64'sd1 <<< FOCAL)) / z;
    end
    r.scr_x = ox[vctp_pkg::SCR_W-1:0];
    r.scr_y = oy[vctp_pkg::SCR_W-1:0];
    t       = z - rd;
    r.depth = t[vctp_pkg::DEPTH_W-1:0];
    r.vx    = x[vctp_pkg::VIEW_W-1:0];
    r.vy    = y[vctp_pkg::VIEW_W-1:0];
    r.vz    = z[vctp_pkg::VIEW_W-1:0];
    r.last  = lst;
    return r;
  endfunction

  task automatic cmp(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      fail_count = fail_count + 1;
    end
  endtask

  assign pending = projections.size();

  always @(posedge clk) begin
    proj_t e;
    if (rst) begin
      model_sc <= 36'd65536; pitch_sc <= 36'd65536; yaw_sc <= 36'd65536;
      ofs_x <= '0; ofs_y <= '0; ofs_z <= '0;
      ctr_x <= 11'd256; ctr_y <= 11'd167;
      projections.delete();
      fail_count    = 0;
      seen_results <= 0;
      seen_clipped <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          vctp_pkg::REG_MODEL_YAW:    model_sc <= wr_data;
          vctp_pkg::REG_CAMERA_PITCH: pitch_sc <= wr_data;
          vctp_pkg::REG_CAMERA_YAW:   yaw_sc   <= wr_data;
          vctp_pkg::REG_OFFSET_X:     ofs_x    <= wr_data[vctp_pkg::OFF_W-1:0];
          vctp_pkg::REG_OFFSET_Y:     ofs_y    <= wr_data[vctp_pkg::OFF_W-1:0];
          vctp_pkg::REG_OFFSET_Z:     ofs_z    <= wr_data[vctp_pkg::OFF_W-1:0];
          vctp_pkg::REG_MID_X:        ctr_x    <= wr_data[vctp_pkg::CTR_W-1:0];
          vctp_pkg::REG_MID_Y:        ctr_y    <= wr_data[vctp_pkg::CTR_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) projections.push_back(project(s_tdata, s_tlast));
      if (m_tvalid && m_tready) begin
        if (projections.size() == 0) begin
          $error("result with nothing expected");
          fail_count = fail_count + 1;
        end else begin
          e = projections.pop_front();
          cmp("screen_x", e.scr_x, m_tdata[18:0]);
          cmp("screen_y", e.scr_y, m_tdata[37:19]);
          cmp("relative_depth", e.depth, m_tdata[54:38]);
          cmp("view_x", e.vx, m_tdata[70:55]);
          cmp("view_y", e.vy, m_tdata[86:71]);
          cmp("view_z", e.vz, m_tdata[102:87]);
          cmp("near_clipped", e.near, m_tuser);
          cmp("last_out", e.last, m_tlast);
          seen_results <= seen_results + 1;
          if (e.near) seen_clipped <= seen_clipped + 1;
        end
      end
    end
  end
endmodule

// ----- bench/tb.sv -----
module tb;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [39:0]  s_tdata = '0;
  logic         s_tlast = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [103:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;
  logic         wr_en = 0;
  logic [vctp_pkg::IDX_W-1:0] wr_index = '0;
  logic [vctp_pkg::SC_W-1:0]  wr_data = '0;
  int fail_count, pending, seen_results, seen_clipped;
  int hold_long = 0;
  int sent = 0;

  always #2 clk = ~clk;

  vertex_camera_transform_project_top u_dut (.*);

  vctp_checker u_chk (.*);

  // sine/cosine word from two signed 18-bit values
  function automatic logic [35:0] sc(int s, int c);
    logic [17:0] a, b;
    a = s[17:0];
    b = c[17:0];
    return {a, b};
  endfunction

  // one write; wr_en is lowered again before the task returns, so back-to-back writes never collide
  task automatic write_reg(logic [vctp_pkg::IDX_W-1:0] idx, logic [vctp_pkg::SC_W-1:0] val);
    wr_en    <= 1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en    <= 0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send(logic [11:0] x, logic [11:0] y, logic [11:0] z, logic lst, int gap);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {4'b0, z, y, x};
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_rand(int n, int mode);
    logic [11:0] x, y, z;
    int g;
    for (int i = 0; i < n; i++) begin
      x = $urandom; y = $urandom; z = $urandom;
      if (mode == 1) begin
        x = $urandom_range(400) - 200;
        y = $urandom_range(400) - 200;
        z = $urandom_range(400) - 200;
      end
      g = ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
      if (mode == 2) g = 0;
      send(x, y, z, $urandom_range(1), g);
    end
    s_tvalid <= 0;
  endtask

  task automatic rand_config(int kind);
    int s, c;
    logic [vctp_pkg::IDX_W-1:0] idx;
    for (int r = 0; r < 3; r++) begin
      case (kind)
        0: begin s = $urandom_range(131071) - 65536; c = $urandom_range(131071) - 65536; end
        1: begin s = $urandom; c = $urandom; end
        default: begin s = (r == 1) ? -131072 : 131071; c = (r == 2) ? -131072 : 131071; end
      endcase
      case (r)
        0: idx = vctp_pkg::REG_MODEL_YAW;
        1: idx = vctp_pkg::REG_CAMERA_PITCH;
        default: idx = vctp_pkg::REG_CAMERA_YAW;
      endcase
      write_reg(idx, sc(s, c));
    end
    write_reg(vctp_pkg::REG_OFFSET_X, $urandom);
    write_reg(vctp_pkg::REG_OFFSET_Y, $urandom);
    write_reg(vctp_pkg::REG_OFFSET_Z,
              (kind == 0) ? 14'd600 + $urandom_range(2000) : 14'($urandom));
    write_reg(vctp_pkg::REG_MID_X, $urandom);
    write_reg(vctp_pkg::REG_MID_Y, $urandom);
  endtask

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    int w;
    m_tready <= 0;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        m_tready <= 0;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end
      w = ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
      if ($urandom_range(4) == 0) w = 0;
      if (w > 0) begin
        m_tready <= 0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) begin
        if (hold_long) break;
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset settings, field extremes, near vertices
    send(12'h000, 12'h000, 12'h000, 0, 0);
    send(12'h7FF, 12'h7FF, 12'h7FF, 1, 0);
    send(12'h800, 12'h800, 12'h800, 0, 3);
    send(12'h7FF, 12'h800, 12'd50, 0, 0);
    send(12'h800, 12'h7FF, 12'd49, 1, 0);
    send(12'hFFF, 12'h001, 12'd51, 0, 1);
    s_tvalid <= 0;
    drain();
    write_reg(vctp_pkg::REG_OFFSET_Z, 14'h1FFF);
    write_reg(vctp_pkg::REG_OFFSET_X, 14'h2000);
    write_reg(vctp_pkg::REG_OFFSET_Y, 14'h1FFF);
    write_reg(vctp_pkg::REG_MID_X, 11'h7FF);
    write_reg(vctp_pkg::REG_MID_Y, 11'h000);
    write_reg(vctp_pkg::REG_MODEL_YAW, sc(-131072, 131071));
    write_reg(vctp_pkg::REG_CAMERA_PITCH, sc(131071, -131072));
    write_reg(vctp_pkg::REG_CAMERA_YAW, sc(-65536, 0));
    send(12'h7FF, 12'h7FF, 12'h7FF, 0, 0);
    send(12'h800, 12'h800, 12'h800, 1, 0);
    send(12'h7FF, 12'h000, 12'h800, 0, 0);
    send(12'h000, 12'h800, 12'h7FF, 1, 0);
    s_tvalid <= 0;
    drain();
    // random phases; mode 1 uses plausible geometry, others raw noise
    for (int p = 0; p < 12; p++) begin
      rand_config(p % 3);
      if (p == 4) hold_long = 1;
      send_rand(95, (p == 4) ? 2 : ((p % 3 == 1) ? 0 : 1));
      drain(); // sender pauses until all results are in
    end
    $display("tb: %0d vertices sent, %0d results checked, %0d near clipped",
             sent, seen_results, seen_clipped);
    $display("tb: 12 register settings incl. trig and offset extremes, long output stall");
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end
endmodule

// ----- vertex_camera_transform_project_top.f -----
hw/rtl/vctp_pkg.sv
hw/rtl/vctp_transform.sv
hw/rtl/vctp_divider.sv
hw/rtl/vertex_camera_transform_project_top.sv
bench/vctp_checker.sv
bench/tb.sv
